/* src/lss_pkg.sv */
package lss_pkg;

    localparam int DEPTH  = 32;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCNT_W = 6;

    localparam logic [2:0] FUNC_PUSH   = 3'd0;
    localparam logic [2:0] FUNC_POP    = 3'd1;
    localparam logic [2:0] FUNC_LIST   = 3'd2;
    localparam logic [2:0] FUNC_SEARCH = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_W-1:0] value;
    } t_request;

    typedef struct packed {
        logic [2:0]               kind;
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic                     found;
        logic [OCNT_W-1:0]        count;
        logic                     last;
    } t_result;

    typedef struct packed {
        logic space_now;
        logic room1;
        logic room2;
    } t_qstat;

    function automatic logic [OCNT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
        return OCNT_W'(c);
    endfunction

endpackage

/* src/lss_ram.sv */
module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lss_outq.sv */
module lss_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lss_pkg::t_result i_res,
    output lss_pkg::t_qstat  o_stat,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output lss_pkg::t_result o_out_res
);

    lss_pkg::t_result r_buf [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_occ;
    logic [1:0]       n_occ;
    logic [1:0]       left;
    logic             pop;

    assign pop   = (r_occ != 2'd0) && !i_out_stall;
    assign left  = r_occ - 2'(pop);
    assign n_occ = left + 2'(i_push);

    assign o_stat.space_now = (r_occ != 2'd2);
    assign o_stat.room1     = (left != 2'd2);
    assign o_stat.room2     = (left == 2'd0);

    assign o_out_valid = (r_occ != 2'd0);
    assign o_out_res   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_occ <= 2'd0;
        end else begin
            r_occ <= n_occ;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_res;
        end
    end

endmodule

/* src/lifo_stack_with_search_core.sv */
// Push, clear and requests on an empty stack: the result goes to the output queue,
// one request per cycle while it has space; unused codes are dropped with no result.
// Pop reads the RAM when idle and emits from S_POP. List of n entries: one result
// per cycle while the queue has room. Search over n entries: one RAM read per cycle.
// Synchronous active-low reset empties the stack and the result queue;
// RAM contents are not cleared.
module lifo_stack_with_search_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lss_pkg::t_request i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lss_pkg::t_result  o_out_res
);

    typedef enum logic [1:0] {S_IDLE, S_POP, S_LIST, S_SEARCH} t_state;

    t_state                        r_state, n_state;
    logic [lss_pkg::CNT_W-1:0]     r_count, n_count;
    logic [lss_pkg::ADDR_W-1:0]    r_idx, n_idx;
    logic                          r_pend, n_pend;
    logic                          r_pend_last, n_pend_last;
    logic                          r_done, n_done;
    logic                          r_hit, n_hit;
    logic [lss_pkg::DATA_W-1:0]    r_key, n_key;

    logic                          in_take;
    logic [lss_pkg::CNT_W-1:0]     cnt_dec;
    logic [lss_pkg::CNT_W-1:0]     idx_inc;
    logic                          hit_now;
    logic                          emit;
    lss_pkg::t_result              res;
    lss_pkg::t_qstat               qstat;

    logic                          we;
    logic [lss_pkg::ADDR_W-1:0]    waddr;
    logic [lss_pkg::DATA_W-1:0]    wdata;
    logic                          re;
    logic [lss_pkg::ADDR_W-1:0]    raddr;
    logic [lss_pkg::DATA_W-1:0]    rdata;

    assign o_in_stall = !((r_state == S_IDLE) && qstat.space_now);
    assign in_take    = i_in_valid && !o_in_stall;
    assign cnt_dec    = r_count - lss_pkg::CNT_W'(1);
    assign idx_inc    = lss_pkg::CNT_W'(r_idx) + lss_pkg::CNT_W'(1);
    assign hit_now    = r_hit || (r_pend && (rdata == r_key));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_done      = r_done;
        n_hit       = r_hit;
        n_key       = r_key;
        we          = 1'b0;
        waddr       = r_count[lss_pkg::ADDR_W-1:0];
        wdata       = i_in_req.value;
        re          = 1'b0;
        raddr       = r_idx;
        emit        = 1'b0;
        res.kind    = i_in_req.func;
        res.status  = lss_pkg::ST_OK;
        res.data    = '0;
        res.found   = 1'b0;
        res.last    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    unique case (i_in_req.func)
                        lss_pkg::FUNC_PUSH: begin
                            emit = 1'b1;
                            if (r_count == lss_pkg::CNT_W'(lss_pkg::DEPTH)) begin
                                res.status = lss_pkg::ST_FULL;
                            end else begin
                                we       = 1'b1;
                                res.data = i_in_req.value;
                                n_count  = r_count + lss_pkg::CNT_W'(1);
                            end
                        end
                        lss_pkg::FUNC_POP: begin
                            if (r_count == '0) begin
                                emit       = 1'b1;
                                res.status = lss_pkg::ST_EMPTY;
                            end else begin
                                re      = 1'b1;
                                raddr   = cnt_dec[lss_pkg::ADDR_W-1:0];
                                n_count = cnt_dec;
                                n_state = S_POP;
                            end
                        end
                        lss_pkg::FUNC_LIST: begin
                            if (r_count == '0) begin
                                emit       = 1'b1;
                                res.status = lss_pkg::ST_EMPTY;
                            end else begin
                                n_idx   = cnt_dec[lss_pkg::ADDR_W-1:0];
                                n_pend  = 1'b0;
                                n_done  = 1'b0;
                                n_state = S_LIST;
                            end
                        end
                        lss_pkg::FUNC_SEARCH: begin
                            if (r_count == '0) begin
                                emit = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_key   = i_in_req.value;
                                n_hit   = 1'b0;
                                n_pend  = 1'b0;
                                n_done  = 1'b0;
                                n_state = S_SEARCH;
                            end
                        end
                        lss_pkg::FUNC_CLEAR: begin
                            emit    = 1'b1;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                emit     = 1'b1;
                res.kind = lss_pkg::FUNC_POP;
                res.data = rdata;
                n_state  = S_IDLE;
            end
            S_LIST: begin
                res.kind = lss_pkg::FUNC_LIST;
                n_pend   = 1'b0;
                if (r_pend) begin
                    emit     = 1'b1;
                    res.data = rdata;
                    res.last = r_pend_last;
                    if (r_pend_last) begin
                        n_state = S_IDLE;
                    end
                end
                if (!r_done && (r_pend ? qstat.room2 : qstat.room1)) begin
                    re          = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = (r_idx == '0);
                    n_done      = (r_idx == '0);
                    n_idx       = r_idx - lss_pkg::ADDR_W'(1);
                end
            end
            S_SEARCH: begin
                res.kind = lss_pkg::FUNC_SEARCH;
                n_pend   = 1'b0;
                n_hit    = hit_now;
                if (r_pend && r_pend_last) begin
                    emit      = 1'b1;
                    res.found = hit_now;
                    n_state   = S_IDLE;
                end
                if (!r_done) begin
                    re          = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = (idx_inc == r_count);
                    n_done      = (idx_inc == r_count);
                    n_idx       = r_idx + lss_pkg::ADDR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        res.count = lss_pkg::cnt_out(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pend_last <= n_pend_last;
        r_hit       <= n_hit;
        r_key       <= n_key;
    end

    lss_ram #(
        .WIDTH(lss_pkg::DATA_W),
        .DEPTH(lss_pkg::DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    lss_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (emit),
        .i_res      (res),
        .o_stat     (qstat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_res  (o_out_res)
    );

endmodule

/* src/lss_checker.sv */
module lss_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input lss_pkg::t_result  o_out_res
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_res.status == lss_pkg::ST_OK)
                     || (o_out_res.status == lss_pkg::ST_EMPTY)
                     || (o_out_res.status == lss_pkg::ST_FULL))
        else $error("bad status code");

    a_found_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.found |-> o_out_res.kind == lss_pkg::FUNC_SEARCH)
        else $error("found outside search");

    a_more_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_res.last |->
            (o_out_res.kind == lss_pkg::FUNC_LIST) && (o_out_res.status == lss_pkg::ST_OK))
        else $error("non-final result outside list");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_res.status == lss_pkg::ST_FULL) |->
            (o_out_res.kind == lss_pkg::FUNC_PUSH) && (o_out_res.data == '0))
        else $error("full status outside dropped push");

endmodule

bind lifo_stack_with_search_core lss_checker u_lss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_res  (o_out_res)
);
